@@ rtl/rigid_body_derived_transform_defines.svh @@
// assertion macros used by the rtl
`ifndef RIGID_BODY_DERIVED_TRANSFORM_DEFINES_SVH
`define RIGID_BODY_DERIVED_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
`define RBDT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbdt check failed");
`define RBDT_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("rbdt reset check failed");
`else
`define RBDT_ASSERT(name, clk, rst_n, prop)
`define RBDT_ASSERT_RST(name, clk, prop)
`endif

`endif

@@ rtl/rbdt_pkg.sv @@
`timescale 1ns / 1ps
package rbdt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int NORM_BITS = 16;
    localparam int FIELD_W   = 32;
    localparam int LEN_W     = $clog2(FIELD_W + 1);

    localparam int C_W   = NORM_BITS + 1;
    localparam int P_W   = 2 * C_W;
    localparam int NUM_W = P_W + 2;
    localparam int NN_W  = 2 * NORM_BITS + 2;
    localparam int DIV_W = NN_W + FRAC_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int R_W   = FRAC_BITS + 2;
    localparam int BP_W  = R_W + FIELD_W;
    localparam int BS_W  = BP_W + 2;
    localparam int T_W   = BS_W - FRAC_BITS;
    localparam int WP_W  = T_W + R_W;
    localparam int WS_W  = WP_W + 2;
    localparam int W_W   = WS_W - FRAC_BITS;

    localparam int NUM_LANES = 9;
    localparam int QDEPTH    = 4;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int QC_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] ROW_LAST = 2'd2;

    localparam logic signed [R_W-1:0]  ONE_R  = R_W'(1) << FRAC_BITS;
    localparam logic signed [BS_W-1:0] HALF_T = BS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [WS_W-1:0] HALF_W = WS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [W_W-1:0]  SAT_HI =
        {{(W_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [W_W-1:0]  SAT_LO = ~SAT_HI;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XX, REG_YY, REG_ZZ, REG_XY, REG_XZ, REG_YZ
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] quat_r;
        logic signed [FIELD_W-1:0] quat_i;
        logic signed [FIELD_W-1:0] quat_j;
        logic signed [FIELD_W-1:0] quat_k;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                row_index;
        logic signed [FIELD_W-1:0] mat_c0;
        logic signed [FIELD_W-1:0] mat_c1;
        logic signed [FIELD_W-1:0] mat_c2;
        logic signed [FIELD_W-1:0] mat_trans;
        logic signed [FIELD_W-1:0] inertia_c0;
        logic signed [FIELD_W-1:0] inertia_c1;
        logic signed [FIELD_W-1:0] inertia_c2;
        logic                      last_row;
    } t_out_item;

    typedef struct packed {
        logic                      we;
        logic [CFG_IDX_W-1:0]      idx;
        logic [FIELD_W-1:0]        data;
    } t_cfg_wr;

    // rotation numerators and squared norm, one request between front and back
    typedef struct packed {
        logic [2:0][FIELD_W-1:0]       pos;
        logic [NUM_LANES-1:0][NUM_W-1:0] num;
        logic [NN_W-1:0]               nn;
        logic                          zero;
    } t_rot_job;

    typedef struct packed {
        logic [2:0][FIELD_W-1:0]       pos;
        logic [NUM_LANES-1:0][R_W-1:0] r;
    } t_rot_mat;

endpackage

@@ rtl/rbdt_div.sv @@
`timescale 1ns / 1ps
module rbdt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_v,
    input  rbdt_pkg::t_rot_job i_job,
    output logic              o_v,
    output rbdt_pkg::t_rot_mat o_rot
);
    import rbdt_pkg::*;

    logic [Q_W:0]         r_v;
    logic [DIV_W-1:0]     r_rem [Q_W+1][NUM_LANES];
    logic [Q_W-1:0]       r_q   [Q_W+1][NUM_LANES];
    logic [NUM_LANES-1:0] r_neg [Q_W+1];
    logic [NN_W-1:0]      r_nn  [Q_W+1];
    logic [2:0][FIELD_W-1:0] r_pos [Q_W+1];
    logic [Q_W:0]         r_zero;

    logic [DIV_W-1:0]     n_rem [Q_W+1][NUM_LANES];
    logic [Q_W-1:0]       n_q   [Q_W+1][NUM_LANES];
    logic [NUM_LANES-1:0] n_neg;

    // stage 0 forms the rounded dividend, stage s settles quotient bit Q_W-s
    always_comb begin
        logic [NUM_W-1:0] mag;
        logic [DIV_W-1:0] dsr;
        logic             ge;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_neg[l] = i_job.num[l][NUM_W-1];
            mag = n_neg[l] ? (~i_job.num[l] + NUM_W'(1)) : i_job.num[l];
            n_rem[0][l] = (DIV_W'(mag[NN_W-1:0]) << FRAC_BITS)
                        + DIV_W'(i_job.nn >> 1);
            n_q[0][l] = '0;
        end
        for (int s = 1; s <= Q_W; s++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                dsr = DIV_W'(r_nn[s-1]) << (Q_W - s);
                ge  = r_rem[s-1][l] >= dsr;
                n_rem[s][l] = ge ? (r_rem[s-1][l] - dsr) : r_rem[s-1][l];
                n_q[s][l]   = {r_q[s-1][l][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[Q_W-1:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg[0]  <= n_neg;
            r_nn[0]   <= i_job.nn;
            r_pos[0]  <= i_job.pos;
            r_zero[0] <= i_job.zero;
            for (int s = 0; s <= Q_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
            for (int s = 1; s <= Q_W; s++) begin
                r_neg[s]  <= r_neg[s-1];
                r_nn[s]   <= r_nn[s-1];
                r_pos[s]  <= r_pos[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    always_comb begin
        o_v       = r_v[Q_W];
        o_rot.pos = r_pos[Q_W];
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_zero[Q_W]) begin
                // zero quaternion gives the identity
                o_rot.r[l] = (l % 4 == 0) ? ONE_R : '0;
            end else if (r_neg[Q_W][l]) begin
                o_rot.r[l] = -R_W'(r_q[Q_W][l]);
            end else begin
                o_rot.r[l] = R_W'(r_q[Q_W][l]);
            end
        end
    end

endmodule

@@ rtl/rbdt_front.sv @@
`timescale 1ns / 1ps
module rbdt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rbdt_pkg::t_in_item i_item,
    output logic               o_job_v,
    output rbdt_pkg::t_rot_job o_job,
    input  logic               i_job_full
);
    import rbdt_pkg::*;

    function automatic logic [LEN_W-1:0] bit_len(input logic [FIELD_W-1:0] v);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (v[i]) len = LEN_W'(i + 1);
        end
        return len;
    endfunction

    logic adv;
    logic [4:0] r_v;

    logic [2:0][FIELD_W-1:0] r_s1_pos, r_s2_pos, r_s3_pos, r_s4_pos;
    logic [FIELD_W-1:0]      r_s1_mag [4];
    logic [FIELD_W-1:0]      r_s2_mag [4];
    logic [3:0]              r_s1_neg, r_s2_neg;
    logic [FIELD_W-1:0]      r_s1_or;
    logic [LEN_W-1:0]        r_s2_len;
    logic                    r_s2_zero, r_s3_zero, r_s4_zero;
    logic signed [C_W-1:0]   r_s3_c [4];
    logic signed [P_W-1:0]   r_rr, r_ii, r_jj, r_kk, r_ij, r_ik, r_jk, r_ri, r_rj, r_rk;
    t_rot_job                r_s5_job;

    logic [FIELD_W-1:0]      n_quat [4];
    logic [FIELD_W-1:0]      n_mag [4];
    logic signed [C_W-1:0]   n_c [4];
    logic signed [NUM_W-1:0] e_rr, e_ii, e_jj, e_kk, e_ij, e_ik, e_jk, e_ri, e_rj, e_rk;
    logic signed [NUM_W-1:0] nn_s;
    t_rot_job                n_job;

    assign adv     = !r_v[4] || !i_job_full;
    assign full    = !adv;
    assign o_job_v = r_v[4];
    assign o_job   = r_s5_job;

    always_comb begin
        n_quat[0] = i_item.quat_r;
        n_quat[1] = i_item.quat_i;
        n_quat[2] = i_item.quat_j;
        n_quat[3] = i_item.quat_k;
        for (int q = 0; q < 4; q++) begin
            n_mag[q] = n_quat[q][FIELD_W-1] ? (~n_quat[q] + FIELD_W'(1)) : n_quat[q];
        end
    end

    // scale so the largest magnitude fills NORM_BITS bits
    always_comb begin
        logic [FIELD_W-1:0] m;
        for (int q = 0; q < 4; q++) begin
            if (r_s2_len > LEN_W'(NORM_BITS)) begin
                m = r_s2_mag[q] >> (r_s2_len - LEN_W'(NORM_BITS));
            end else begin
                m = r_s2_mag[q] << (LEN_W'(NORM_BITS) - r_s2_len);
            end
            n_c[q] = r_s2_neg[q] ? -$signed({1'b0, m[NORM_BITS-1:0]})
                                 : $signed({1'b0, m[NORM_BITS-1:0]});
        end
    end

    always_comb begin
        e_rr = NUM_W'(r_rr);
        e_ii = NUM_W'(r_ii);
        e_jj = NUM_W'(r_jj);
        e_kk = NUM_W'(r_kk);
        e_ij = NUM_W'(r_ij);
        e_ik = NUM_W'(r_ik);
        e_jk = NUM_W'(r_jk);
        e_ri = NUM_W'(r_ri);
        e_rj = NUM_W'(r_rj);
        e_rk = NUM_W'(r_rk);
        nn_s = e_rr + e_ii + e_jj + e_kk;
        n_job.pos    = r_s4_pos;
        n_job.zero   = r_s4_zero;
        n_job.nn     = nn_s[NN_W-1:0];
        n_job.num[0] = nn_s - ((e_jj + e_kk) <<< 1);
        n_job.num[1] = (e_ij - e_rk) <<< 1;
        n_job.num[2] = (e_ik + e_rj) <<< 1;
        n_job.num[3] = (e_ij + e_rk) <<< 1;
        n_job.num[4] = nn_s - ((e_ii + e_kk) <<< 1);
        n_job.num[5] = (e_jk - e_ri) <<< 1;
        n_job.num[6] = (e_ik - e_rj) <<< 1;
        n_job.num[7] = (e_jk + e_ri) <<< 1;
        n_job.num[8] = nn_s - ((e_ii + e_jj) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[3:0], push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_pos <= {i_item.pos_z, i_item.pos_y, i_item.pos_x};
            r_s1_or  <= n_mag[0] | n_mag[1] | n_mag[2] | n_mag[3];
            for (int q = 0; q < 4; q++) begin
                r_s1_mag[q] <= n_mag[q];
                r_s1_neg[q] <= n_quat[q][FIELD_W-1];
            end

            r_s2_pos  <= r_s1_pos;
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_len  <= bit_len(r_s1_or);
            r_s2_zero <= (r_s1_or == '0);

            r_s3_pos  <= r_s2_pos;
            r_s3_zero <= r_s2_zero;
            r_s3_c    <= n_c;

            r_s4_pos  <= r_s3_pos;
            r_s4_zero <= r_s3_zero;
            r_rr <= r_s3_c[0] * r_s3_c[0];
            r_ii <= r_s3_c[1] * r_s3_c[1];
            r_jj <= r_s3_c[2] * r_s3_c[2];
            r_kk <= r_s3_c[3] * r_s3_c[3];
            r_ij <= r_s3_c[1] * r_s3_c[2];
            r_ik <= r_s3_c[1] * r_s3_c[3];
            r_jk <= r_s3_c[2] * r_s3_c[3];
            r_ri <= r_s3_c[0] * r_s3_c[1];
            r_rj <= r_s3_c[0] * r_s3_c[2];
            r_rk <= r_s3_c[0] * r_s3_c[3];

            r_s5_job <= n_job;
        end
    end

endmodule

@@ rtl/rbdt_queue.sv @@
`timescale 1ns / 1ps
module rbdt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_v,
    input  rbdt_pkg::t_rot_job i_wr_data,
    output logic               o_full,
    output logic               o_rd_v,
    output rbdt_pkg::t_rot_job o_rd_data,
    input  logic               i_rd
);
    import rbdt_pkg::*;

    t_rot_job          r_mem [QDEPTH];
    logic [QA_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QC_W-1:0]   r_count;
    logic              wr, rd;

    assign o_full    = (r_count == QC_W'(QDEPTH));
    assign o_rd_v    = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr        = i_wr_v && !o_full;
    assign rd        = i_rd && o_rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= r_wr_ptr + QA_W'(1);
            if (rd) r_rd_ptr <= r_rd_ptr + QA_W'(1);
            case ({wr, rd})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_wr_data;
    end

endmodule

@@ rtl/rbdt_back.sv @@
`timescale 1ns / 1ps
`include "rigid_body_derived_transform_defines.svh"
module rbdt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbdt_pkg::t_cfg_wr   i_cfg,
    input  logic                i_job_v,
    input  rbdt_pkg::t_rot_job  i_job,
    output logic                o_job_rd,
    output logic                empty,
    input  logic                pop,
    output rbdt_pkg::t_out_item o_result
);
    import rbdt_pkg::*;

    function automatic logic [FIELD_W-1:0] sat_field(input logic signed [W_W-1:0] v);
        if (v > SAT_HI) return SAT_HI[FIELD_W-1:0];
        if (v < SAT_LO) return SAT_LO[FIELD_W-1:0];
        return v[FIELD_W-1:0];
    endfunction

    logic signed [FIELD_W-1:0] r_inv [6];
    logic signed [FIELD_W-1:0] bmat [3][3];

    logic     adv, div_adv, div_v, seq_take, seq_load;
    t_rot_mat div_rot;

    logic     r_seq_v;
    logic [1:0] r_seq_row;
    t_rot_mat r_seq_rot;

    logic     r_t1_v, r_t2_v, r_t3_v, r_out_v;
    logic [1:0] r_t1_row, r_t2_row, r_t3_row;
    t_rot_mat r_t1_rot, r_t2_rot, r_t3_rot;
    logic signed [BP_W-1:0] r_t1_p [3][3];
    logic signed [T_W-1:0]  r_t2_t [3];
    logic signed [WP_W-1:0] r_t3_p [3][3];
    t_out_item r_out;

    logic signed [BP_W-1:0] n_t1_p [3][3];
    logic signed [T_W-1:0]  n_t2_t [3];
    logic signed [WP_W-1:0] n_t3_p [3][3];
    logic [FIELD_W-1:0]     n_w [3];
    t_out_item n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv[REG_XX] <= FIELD_W'(1) << FRAC_BITS;
            r_inv[REG_YY] <= FIELD_W'(1) << FRAC_BITS;
            r_inv[REG_ZZ] <= FIELD_W'(1) << FRAC_BITS;
            r_inv[REG_XY] <= '0;
            r_inv[REG_XZ] <= '0;
            r_inv[REG_YZ] <= '0;
        end else if (i_cfg.we) begin
            case (t_reg_idx'(i_cfg.idx))
                REG_XX:  r_inv[REG_XX] <= i_cfg.data;
                REG_YY:  r_inv[REG_YY] <= i_cfg.data;
                REG_ZZ:  r_inv[REG_ZZ] <= i_cfg.data;
                REG_XY:  r_inv[REG_XY] <= i_cfg.data;
                REG_XZ:  r_inv[REG_XZ] <= i_cfg.data;
                REG_YZ:  r_inv[REG_YZ] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        bmat[0][0] = r_inv[REG_XX];
        bmat[1][1] = r_inv[REG_YY];
        bmat[2][2] = r_inv[REG_ZZ];
        bmat[0][1] = r_inv[REG_XY];
        bmat[1][0] = r_inv[REG_XY];
        bmat[0][2] = r_inv[REG_XZ];
        bmat[2][0] = r_inv[REG_XZ];
        bmat[1][2] = r_inv[REG_YZ];
        bmat[2][1] = r_inv[REG_YZ];
    end

    // the whole row pipeline moves when the output slot frees
    assign adv      = !r_out_v || pop;
    assign seq_take = !r_seq_v || (r_seq_row == ROW_LAST && adv);
    assign div_adv  = !div_v || seq_take;
    assign seq_load = div_v && seq_take;
    assign o_job_rd = div_adv;

    rbdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (div_adv),
        .i_v     (i_job_v),
        .i_job   (i_job),
        .o_v     (div_v),
        .o_rot   (div_rot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_v   <= 1'b0;
            r_seq_row <= '0;
        end else if (seq_take) begin
            r_seq_v   <= div_v;
            r_seq_row <= '0;
        end else if (r_seq_v && adv) begin
            r_seq_row <= r_seq_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_load) r_seq_rot <= div_rot;
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                n_t1_p[a][c] = $signed(r_seq_rot.r[3 * r_seq_row + c]) * bmat[a][c];
            end
        end
    end

    // row of R*B, rounded half up
    always_comb begin
        logic signed [BS_W-1:0] sum;
        for (int a = 0; a < 3; a++) begin
            sum = BS_W'(r_t1_p[a][0]) + BS_W'(r_t1_p[a][1]) + BS_W'(r_t1_p[a][2]) + HALF_T;
            sum = sum >>> FRAC_BITS;
            n_t2_t[a] = sum[T_W-1:0];
        end
    end

    always_comb begin
        for (int s = 0; s < 3; s++) begin
            for (int a = 0; a < 3; a++) begin
                n_t3_p[s][a] = r_t2_t[a] * $signed(r_t2_rot.r[3 * s + a]);
            end
        end
    end

    always_comb begin
        logic signed [WS_W-1:0] sum;
        for (int s = 0; s < 3; s++) begin
            sum = WS_W'(r_t3_p[s][0]) + WS_W'(r_t3_p[s][1]) + WS_W'(r_t3_p[s][2]) + HALF_W;
            sum = sum >>> FRAC_BITS;
            n_w[s] = sat_field(sum[W_W-1:0]);
        end
        n_out.row_index  = r_t3_row;
        n_out.mat_c0     = FIELD_W'($signed(r_t3_rot.r[3 * r_t3_row]));
        n_out.mat_c1     = FIELD_W'($signed(r_t3_rot.r[3 * r_t3_row + 1]));
        n_out.mat_c2     = FIELD_W'($signed(r_t3_rot.r[3 * r_t3_row + 2]));
        n_out.mat_trans  = r_t3_rot.pos[r_t3_row];
        n_out.inertia_c0 = n_w[0];
        n_out.inertia_c1 = n_w[1];
        n_out.inertia_c2 = n_w[2];
        n_out.last_row   = (r_t3_row == ROW_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v  <= 1'b0;
            r_t2_v  <= 1'b0;
            r_t3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_t1_v  <= r_seq_v;
            r_t2_v  <= r_t1_v;
            r_t3_v  <= r_t2_v;
            r_out_v <= r_t3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1_row <= r_seq_row;
            r_t1_rot <= r_seq_rot;
            r_t1_p   <= n_t1_p;
            r_t2_row <= r_t1_row;
            r_t2_rot <= r_t1_rot;
            r_t2_t   <= n_t2_t;
            r_t3_row <= r_t2_row;
            r_t3_rot <= r_t2_rot;
            r_t3_p   <= n_t3_p;
            r_out    <= n_out;
        end
    end

    assign empty    = !r_out_v;
    assign o_result = r_out;

    `RBDT_ASSERT(a_seq_row_range, i_clk, i_rst_n, r_seq_row <= ROW_LAST)
    `RBDT_ASSERT(a_seq_load_row0, i_clk, i_rst_n, seq_load |=> (r_seq_row == 2'd0))
    `RBDT_ASSERT(a_div_hold, i_clk, i_rst_n, (div_v && !div_adv) |=> div_v)
    `RBDT_ASSERT(a_out_last, i_clk, i_rst_n, r_out_v |-> (r_out.last_row == (r_out.row_index == ROW_LAST)))
    `RBDT_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> (!r_out_v && !r_seq_v))

endmodule

@@ rtl/rigid_body_derived_transform.sv @@
`timescale 1ns / 1ps
// Takes a body position and orientation quaternion per request and returns three
// result rows in order (row 0, 1, 2; last_row marks row 2), each with one row of
// the rotation, the translation component and one row of the world inverse inertia
// tensor R*B*R^T built from the configured body tensor. The row sequencer in the
// back part takes a new rotation only as it emits the last row of the one before,
// and emits one row per cycle while the output is not stalled. From push to the
// first row a request passes five front stages, the four-entry queue, an 18-stage
// divider (dividend set-up, then one quotient bit per stage) that forms the nine
// normalised rotation entries in parallel, the row sequencer and four tensor stages.
// The front keeps taking requests while results wait, until the queue between the parts fills.
module rigid_body_derived_transform (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  rbdt_pkg::t_in_item        i_item,
    output logic                      empty,
    input  logic                      pop,
    output rbdt_pkg::t_out_item       o_result,
    input  logic                      i_cfg_we,
    input  logic [rbdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbdt_pkg::FIELD_W-1:0]   i_cfg_data
);
    import rbdt_pkg::*;

    logic     job_v, q_full, q_rd_v, q_rd;
    t_rot_job job, q_job;
    t_cfg_wr  cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    rbdt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_job_v    (job_v),
        .o_job      (job),
        .i_job_full (q_full)
    );

    rbdt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_v    (job_v),
        .i_wr_data (job),
        .o_full    (q_full),
        .o_rd_v    (q_rd_v),
        .o_rd_data (q_job),
        .i_rd      (q_rd)
    );

    rbdt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_job_v  (q_rd_v),
        .i_job    (q_job),
        .o_job_rd (q_rd),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
